>>> rtl/core/size_class_pool_allocator_unit_assert.svh
// Assertion macros shared by the pool allocator RTL.
`ifndef SIZE_CLASS_POOL_ALLOCATOR_UNIT_ASSERT_SVH
`define SIZE_CLASS_POOL_ALLOCATOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SCPA_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define SCPA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Invariant checked every cycle outside reset.
`define SCPA_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error(msg);

`endif

>>> rtl/core/scpa_pkg.sv
// Types and constants of the size-class pool allocator.
`default_nettype none

package scpa_pkg;

   // Field widths of the request and response words
   localparam int SIZE_W   = 8;
   localparam int INDEX_W  = 5;
   localparam int GRANT_W  = 5;
   localparam int CLASS_W  = 2;
   localparam int STATUS_W = 2;

   // Block size of class 0; class c holds blocks of this size shifted by c
   localparam logic [31:0] SMALLEST_BLOCK = 32'd8;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EXHAUSTED = 2'd1,
      STATUS_TOO_LARGE = 2'd2
   } status_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;   // take the request word, launch the link read
      logic commit;    // apply the update and load the response word
   } scpa_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic slot_free; // response register can take a new word
   } scpa_stat_type;

endpackage

`default_nettype wire

>>> rtl/core/scpa_req_if.sv
// Request channel of the pool allocator.
`default_nettype none

interface scpa_req_if;
   logic                          valid;
   logic                          ready;
   scpa_pkg::opcode_type          opcode;
   logic [scpa_pkg::SIZE_W-1:0]   request_size;
   logic [scpa_pkg::INDEX_W-1:0]  block_index;

   modport source (output valid, opcode, request_size, block_index, input ready);
   modport sink   (input valid, opcode, request_size, block_index, output ready);
endinterface

`default_nettype wire

>>> rtl/core/scpa_rsp_if.sv
// Response channel of the pool allocator.
`default_nettype none

interface scpa_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [scpa_pkg::GRANT_W-1:0]  granted_index;
   logic [scpa_pkg::CLASS_W-1:0]  size_class;
   scpa_pkg::status_type          status;

   modport source (output valid, granted_index, size_class, status, input ready);
   modport sink   (input valid, granted_index, size_class, status, output ready);
endinterface

`default_nettype wire

>>> rtl/core/scpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module scpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                        clock,
   input  wire logic                                        wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                            wr_data,
   input  wire logic                                        rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                            rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; data holds between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

`default_nettype wire

>>> rtl/core/scpa_ctrl.sv
// Sequencer of the pool allocator: capture a request, then commit it.
`default_nettype none
`include "size_class_pool_allocator_unit_assert.svh"

module scpa_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output      logic                    req_ready,
   input  wire scpa_pkg::scpa_stat_type stat,
   output      scpa_pkg::scpa_cmd_type  cmd
);
   import scpa_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Accept only in idle; commit once the response register frees up
   always_comb begin
      req_ready   = (state_ff == ST_IDLE);
      cmd.capture = (state_ff == ST_IDLE) && req_valid;
      cmd.commit  = (state_ff == ST_EXEC) && stat.slot_free;
   end

   // Advance the state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.capture) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (cmd.commit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `SCPA_ASSERT_ALWAYS(a_state_onehot, clock, reset, $onehot(state_ff), "state not one-hot")
   `SCPA_ASSERT_NEXT(a_capture_exec, clock, reset, cmd.capture, state_ff == ST_EXEC, "capture did not start execution")
   `SCPA_ASSERT_NEXT(a_commit_idle, clock, reset, cmd.commit, state_ff == ST_IDLE, "commit did not return to idle")
   `SCPA_ASSERT_IMPLY(a_no_overlap, clock, reset, cmd.capture, !cmd.commit, "capture and commit in one cycle")
endmodule

`default_nettype wire

>>> rtl/core/scpa_datapath.sv
// Datapath of the pool allocator: list heads, bump counters, link RAM, response register.
`default_nettype none
`include "size_class_pool_allocator_unit_assert.svh"

module scpa_datapath #(
   parameter int BLOCKS_PER_POOL = 32,
   parameter int NUM_CLASSES     = 4
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire scpa_pkg::scpa_cmd_type          cmd,
   output      scpa_pkg::scpa_stat_type         stat,
   input  wire scpa_pkg::opcode_type            req_opcode,
   input  wire logic [scpa_pkg::SIZE_W-1:0]     req_request_size,
   input  wire logic [scpa_pkg::INDEX_W-1:0]    req_block_index,
   output      logic                            rsp_valid,
   input  wire logic                            rsp_ready,
   output      logic [scpa_pkg::GRANT_W-1:0]    rsp_granted_index,
   output      logic [scpa_pkg::CLASS_W-1:0]    rsp_size_class,
   output      scpa_pkg::status_type            rsp_status
);
   import scpa_pkg::*;

   localparam int IDX_W  = (BLOCKS_PER_POOL > 1) ? $clog2(BLOCKS_PER_POOL) : 1;
   localparam int CNT_W  = $clog2(BLOCKS_PER_POOL + 1);
   localparam int CLS_W  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
   localparam int ADDR_W = CLS_W + IDX_W;
   localparam int LINK_W = IDX_W + 1;
   localparam int RAM_DEPTH = 1 << ADDR_W;

   // Per-class list and bump state
   logic [IDX_W-1:0] list_head_ff     [NUM_CLASSES];
   logic             list_nonempty_ff [NUM_CLASSES];
   logic [CNT_W-1:0] fresh_count_ff   [NUM_CLASSES];

   // Captured request and class state
   opcode_type       op_ff;
   logic             fit_ff;
   logic [CLS_W-1:0] cls_ff;
   logic [IDX_W-1:0] idx_ff;
   logic             in_pool_ff;
   logic [INDEX_W-1:0] echo_ff;
   logic [IDX_W-1:0] head_ff;
   logic             nonempty_ff;
   logic [CNT_W-1:0] fresh_ff;

   // Response register
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [GRANT_W-1:0] rsp_grant_ff;
   logic [CLASS_W-1:0] rsp_cls_ff;
   status_type         rsp_status_ff;

   // Decode and link RAM signals
   logic                     dec_fit;
   logic [CLS_W-1:0]         dec_cls;
   logic [IDX_W+INDEX_W-1:0] idx_wide;
   logic                     dec_in_pool;
   logic [ADDR_W-1:0]        rd_addr;
   logic [ADDR_W-1:0]        wr_addr;
   logic [LINK_W-1:0]        wr_link;
   logic [LINK_W-1:0]        rd_link;
   logic                     do_pop;
   logic                     do_fresh;
   logic                     do_push;
   logic [IDX_W+GRANT_W-1:0] head_wide;
   logic [IDX_W+GRANT_W-1:0] fresh_wide;
   logic [CLS_W+CLASS_W-1:0] cls_wide;
   logic [GRANT_W-1:0]       res_grant;
   logic [CLASS_W-1:0]       res_cls;
   status_type               res_status;

   // Pick the smallest class whose block size covers the request
   always_comb begin
      dec_fit = 1'b0;
      dec_cls = '0;
      for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
         if ({24'd0, req_request_size} <= (SMALLEST_BLOCK << c)) begin
            dec_fit = 1'b1;
            dec_cls = CLS_W'(c);
         end
      end
   end

   assign idx_wide    = {{IDX_W{1'b0}}, req_block_index};
   assign dec_in_pool = (idx_wide < (IDX_W + INDEX_W)'(BLOCKS_PER_POOL));
   assign rd_addr     = {dec_cls, list_head_ff[dec_cls]};

   // Capture the request word with its class state; the link read goes out now
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff       <= req_opcode;
         fit_ff      <= dec_fit;
         cls_ff      <= dec_cls;
         idx_ff      <= idx_wide[IDX_W-1:0];
         in_pool_ff  <= dec_in_pool;
         echo_ff     <= req_block_index;
         head_ff     <= list_head_ff[dec_cls];
         nonempty_ff <= list_nonempty_ff[dec_cls];
         fresh_ff    <= fresh_count_ff[dec_cls];
      end
   end

   // Link store: next block and its valid flag, one entry per class and block
   scpa_ram #(
      .WIDTH (LINK_W),
      .DEPTH (RAM_DEPTH)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (cmd.commit && do_push),
      .wr_addr (wr_addr),
      .wr_data (wr_link),
      .rd_en   (cmd.capture),
      .rd_addr (rd_addr),
      .rd_data (rd_link)
   );

   assign wr_addr = {cls_ff, idx_ff};
   assign wr_link = {nonempty_ff, head_ff};

   // Classify the operation
   assign do_pop   = fit_ff && (op_ff == OP_ALLOC) && nonempty_ff;
   assign do_fresh = fit_ff && (op_ff == OP_ALLOC) && !nonempty_ff
                     && (fresh_ff < CNT_W'(BLOCKS_PER_POOL));
   assign do_push  = fit_ff && (op_ff == OP_FREE) && in_pool_ff;

   assign head_wide  = {{GRANT_W{1'b0}}, head_ff};
   assign fresh_wide = {{GRANT_W{1'b0}}, fresh_ff[IDX_W-1:0]};
   assign cls_wide   = {{CLASS_W{1'b0}}, cls_ff};

   // Build the response word
   always_comb begin
      res_grant  = '0;
      res_cls    = '0;
      res_status = STATUS_OK;
      if (!fit_ff) begin
         res_status = STATUS_TOO_LARGE;
      end else begin
         res_cls = cls_wide[CLASS_W-1:0];
         if (op_ff == OP_FREE) begin
            res_grant = echo_ff;
         end else if (do_pop) begin
            res_grant = head_wide[GRANT_W-1:0];
         end else if (do_fresh) begin
            res_grant = fresh_wide[GRANT_W-1:0];
         end else begin
            res_status = STATUS_EXHAUSTED;
         end
      end
   end

   // Update list heads and bump counters on commit
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CLASSES; c++) begin
            list_head_ff[c]     <= '0;
            list_nonempty_ff[c] <= 1'b0;
            fresh_count_ff[c]   <= '0;
         end
      end else if (cmd.commit) begin
         if (do_pop) begin
            list_head_ff[cls_ff]     <= rd_link[IDX_W-1:0];
            list_nonempty_ff[cls_ff] <= rd_link[IDX_W];
         end
         if (do_push) begin
            list_head_ff[cls_ff]     <= idx_ff;
            list_nonempty_ff[cls_ff] <= 1'b1;
         end
         if (do_fresh) begin
            fresh_count_ff[cls_ff] <= fresh_ff + CNT_W'(1);
         end
      end
   end

   // Response register: load on commit, drop when taken
   assign stat.slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_grant_ff  <= res_grant;
         rsp_cls_ff    <= res_cls;
         rsp_status_ff <= res_status;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_granted_index = rsp_grant_ff;
   assign rsp_size_class    = rsp_cls_ff;
   assign rsp_status        = rsp_status_ff;

   `SCPA_ASSERT_IMPLY(a_commit_slot, clock, reset, cmd.commit, !rsp_valid_ff || rsp_ready, "commit overwrote a pending response")
   `SCPA_ASSERT_IMPLY(a_rise_commit, clock, reset, $rose(rsp_valid_ff), $past(cmd.commit), "response appeared without commit")
   `SCPA_ASSERT_IMPLY(a_too_large, clock, reset, rsp_valid_ff && (rsp_status_ff == STATUS_TOO_LARGE), (rsp_grant_ff == '0) && (rsp_cls_ff == '0), "too-large response carries data")
endmodule

`default_nettype wire

>>> rtl/core/size_class_pool_allocator_unit.sv
// Top level of the size-class pool allocator.
`default_nettype none

// Four-class (by default) fixed-block pool allocator. A request word picks the
// smallest class whose block size (8 << class bytes) covers request_size;
// an allocate pops that class's LIFO free list, falls back to a bump counter
// of never-used blocks, and otherwise reports the pool exhausted; a free pushes
// block_index on the class's list when it lies inside the pool. A request has a
// capture step and a commit step: the cycle in which it is accepted reads the
// list head and launches the read of its successor from the link RAM; the commit
// step, once the response register is free, applies the update and loads the
// response word, which can be taken at the following edge. The registered read
// port of the link RAM keeps the steps apart; a new request is accepted only after
// the last one commits, and a held response word stalls the commit and the input.
// Freeing a block never allocated, or freeing twice, is not checked. The link RAM
// is never cleared; only words written by a free are ever read back, so the
// block is ready right out of reset.
module size_class_pool_allocator_unit #(
   parameter int BLOCKS_PER_POOL = 32,
   parameter int NUM_CLASSES     = 4
) (
   input  wire logic  clock,
   input  wire logic  reset,
   scpa_req_if.sink   req_ch,
   scpa_rsp_if.source rsp_ch
);
   import scpa_pkg::*;

   scpa_cmd_type  cmd;
   scpa_stat_type stat;

   scpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   scpa_datapath #(
      .BLOCKS_PER_POOL (BLOCKS_PER_POOL),
      .NUM_CLASSES     (NUM_CLASSES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_opcode        (req_ch.opcode),
      .req_request_size  (req_ch.request_size),
      .req_block_index   (req_ch.block_index),
      .rsp_valid         (rsp_ch.valid),
      .rsp_ready         (rsp_ch.ready),
      .rsp_granted_index (rsp_ch.granted_index),
      .rsp_size_class    (rsp_ch.size_class),
      .rsp_status        (rsp_ch.status)
   );
endmodule

`default_nettype wire

>>> verif/size_class_pool_allocator_unit_grant_check.sv
// Grant checker for the pool allocator: predicts each response word and compares it.

module size_class_pool_allocator_unit_grant_check #(
   parameter int BLOCKS_PER_POOL = 32,
   parameter int NUM_CLASSES     = 4
) (
   input  wire logic   clock,
   input  wire logic   reset,
   scpa_req_if         req_ch,
   scpa_rsp_if         rsp_ch,
   output int unsigned mismatch_count,
   output int unsigned waiting_grants
);
   import scpa_pkg::*;

   typedef struct packed {
      logic [GRANT_W-1:0] granted_index;
      logic [CLASS_W-1:0] size_class;
      status_type         status;
   } grant_word_type;

   // Predicted allocator state
   logic [INDEX_W-1:0] free_head      [NUM_CLASSES];
   logic               head_valid     [NUM_CLASSES];
   logic [INDEX_W-1:0] next_free_link [NUM_CLASSES][BLOCKS_PER_POOL];
   logic               link_live      [NUM_CLASSES][BLOCKS_PER_POOL];
   int unsigned        bump_count     [NUM_CLASSES];

   // Response words still owed by the block, oldest first
   grant_word_type pending_grants [$];

   task automatic report_mismatch(input string line);
      $display("MISMATCH at %0t: %s", $realtime, line);
      mismatch_count++;
   endtask

   // Pick the class, then pop, bump, or push; update the predicted state.
   task automatic serve_request(input opcode_type op, input logic [SIZE_W-1:0] size,
                                input logic [INDEX_W-1:0] idx, output grant_word_type want);
      int cls;
      cls = -1;
      want.granted_index = '0;
      want.size_class    = '0;
      want.status        = STATUS_OK;
      for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
         if (32'(size) <= (SMALLEST_BLOCK << c)) cls = c;
      end
      if (cls < 0) begin
         want.status = STATUS_TOO_LARGE;
      end else begin
         want.size_class = CLASS_W'(cls);
         if (op == OP_ALLOC) begin
            if (head_valid[cls]) begin
               want.granted_index = free_head[cls];
               free_head[cls]  = next_free_link[cls][want.granted_index];
               head_valid[cls] = link_live[cls][want.granted_index];
            end else if (bump_count[cls] < BLOCKS_PER_POOL) begin
               want.granted_index = GRANT_W'(bump_count[cls]);
               bump_count[cls]++;
            end else begin
               want.status = STATUS_EXHAUSTED;
            end
         end else begin
            want.granted_index = idx;
            // an index outside the pool is echoed and otherwise dropped
            if (int'(idx) < BLOCKS_PER_POOL) begin
               next_free_link[cls][idx] = free_head[cls];
               link_live[cls][idx]      = head_valid[cls];
               free_head[cls]           = idx;
               head_valid[cls]          = 1'b1;
            end
         end
      end
   endtask

   always @(posedge clock) begin : watch
      grant_word_type want;
      if (reset) begin
         for (int c = 0; c < NUM_CLASSES; c++) begin
            free_head[c]  = '0;
            head_valid[c] = 1'b0;
            bump_count[c] = 0;
         end
         pending_grants.delete();
         mismatch_count = 0;
      end else begin
         // compare a returned word against the oldest prediction
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_grants.size() == 0) begin
               report_mismatch($sformatf("response word with nothing outstanding (index %0d)",
                                         rsp_ch.granted_index));
            end else begin
               want = pending_grants.pop_front();
               if (rsp_ch.granted_index !== want.granted_index)
                  report_mismatch($sformatf("granted_index got %0d, expected %0d",
                                            rsp_ch.granted_index, want.granted_index));
               if (rsp_ch.size_class !== want.size_class)
                  report_mismatch($sformatf("size_class got %0d, expected %0d",
                                            rsp_ch.size_class, want.size_class));
               if (rsp_ch.status !== want.status)
                  report_mismatch($sformatf("status got %0d, expected %0d",
                                            rsp_ch.status, want.status));
            end
         end
         // predict the word for each accepted request
         if (req_ch.valid && req_ch.ready) begin
            serve_request(req_ch.opcode, req_ch.request_size, req_ch.block_index, want);
            pending_grants.push_back(want);
         end
      end
      waiting_grants = pending_grants.size();
   end

endmodule

>>> verif/size_class_pool_allocator_unit_tb.sv
// Top of the pool allocator testbench: clock, reset, request traffic and verdict.

module size_class_pool_allocator_unit_tb;
   import scpa_pkg::*;

   localparam int BLOCKS_PER_POOL  = 32;
   localparam int NUM_CLASSES      = 4;
   localparam int PHASES           = 10;
   localparam int PHASE_ITEMS      = 95;
   localparam int LONG_HOLD_AT     = 700;
   localparam int LONG_HOLD_CYCLES = 120;
   localparam int unsigned CYCLE_LIMIT = 200000;

   logic clock;
   logic reset;

   scpa_req_if req_ch ();
   scpa_rsp_if rsp_ch ();

   int unsigned mismatch_count;
   int unsigned waiting_grants;
   int unsigned cycle_count = 0;

   // stimulus bookkeeping
   logic        offering = 1'b0;
   int unsigned burst_left = 1;
   int unsigned alloc_sent = 0, free_sent = 0;
   int unsigned ok_seen = 0, exhausted_seen = 0, too_large_seen = 0;
   opcode_type  sent_ops [$];
   logic [INDEX_W-1:0] held_blocks [NUM_CLASSES][$];

   size_class_pool_allocator_unit #(
      .BLOCKS_PER_POOL(BLOCKS_PER_POOL),
      .NUM_CLASSES    (NUM_CLASSES)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   size_class_pool_allocator_unit_grant_check #(
      .BLOCKS_PER_POOL(BLOCKS_PER_POOL),
      .NUM_CLASSES    (NUM_CLASSES)
   ) grant_check (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .mismatch_count(mismatch_count),
      .waiting_grants(waiting_grants)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // Track which blocks are out on loan so frees can hand them back.
   always @(posedge clock) begin : track_grants
      opcode_type op_done;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready && sent_ops.size() != 0) begin
            op_done = sent_ops.pop_front();
            case (rsp_ch.status)
               STATUS_OK:        ok_seen++;
               STATUS_EXHAUSTED: exhausted_seen++;
               default:          too_large_seen++;
            endcase
            if (op_done == OP_ALLOC && rsp_ch.status == STATUS_OK)
               held_blocks[rsp_ch.size_class].push_back(rsp_ch.granted_index);
         end
         if (req_ch.valid && req_ch.ready) sent_ops.push_back(req_ch.opcode);
      end
   end

   // Stall the response side on shifting patterns, with one long hold-off.
   initial begin : receiver
      int unsigned rx_cycle, hold_left, mode;
      rx_cycle  = 0;
      hold_left = 0;
      mode      = 0;
      forever begin
         if (rx_cycle % 40 == 0) mode = $urandom_range(0, 3);
         if (rx_cycle == LONG_HOLD_AT) hold_left = LONG_HOLD_CYCLES;
         if (hold_left != 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else begin
            case (mode)
               0:       rsp_ch.ready <= 1'b1;
               1:       rsp_ch.ready <= (rx_cycle % 4 != 3);
               2:       rsp_ch.ready <= 1'($urandom_range(0, 1));
               default: rsp_ch.ready <= (rx_cycle % 5 == 0);
            endcase
         end
         @(posedge clock);
         rx_cycle++;
      end
   end

   // Offer one word, hold it until taken, then maybe open a gap.
   task automatic offer_word(input opcode_type op, input logic [SIZE_W-1:0] size,
                             input logic [INDEX_W-1:0] idx);
      int unsigned gap;
      req_ch.valid        <= 1'b1;
      req_ch.opcode       <= op;
      req_ch.request_size <= size;
      req_ch.block_index  <= idx;
      offering = 1'b1;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (op == OP_ALLOC) alloc_sent++;
      else free_sent++;
      burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap        = $urandom_range(0, 6);
         if (gap != 0) begin
            req_ch.valid <= 1'b0;
            offering = 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Build one random request: mostly well-formed traffic, some noise.
   task automatic random_request(input int unsigned alloc_pct, input int unsigned focus);
      opcode_type         op;
      int unsigned        cls, pos;
      logic [SIZE_W-1:0]  size;
      logic [INDEX_W-1:0] idx;
      op  = ($urandom_range(0, 99) < alloc_pct) ? OP_ALLOC : OP_FREE;
      idx = INDEX_W'($urandom_range(0, BLOCKS_PER_POOL - 1));
      if ($urandom_range(0, 99) < 5) begin
         size = SIZE_W'($urandom_range(65, 255));
      end else begin
         cls = (focus < NUM_CLASSES && $urandom_range(0, 99) < 70) ? focus
                                                                  : $urandom_range(0, 3);
         if (cls == 0) size = SIZE_W'($urandom_range(0, 8));
         else size = SIZE_W'($urandom_range((8 << (cls - 1)) + 1, 8 << cls));
         // hand back a block we hold; otherwise free an arbitrary index
         if (op == OP_FREE && held_blocks[cls].size() != 0 && $urandom_range(0, 99) < 95) begin
            pos = $urandom_range(0, held_blocks[cls].size() - 1);
            idx = held_blocks[cls][pos];
            held_blocks[cls].delete(pos);
         end
      end
      offer_word(op, size, idx);
   endtask

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Timeout after %0d cycles", cycle_count);
      $display("Regression FAIL");
      $finish;
   end

   initial begin : stimulus
      int unsigned alloc_pct, focus;
      reset               <= 1'b1;
      req_ch.valid        <= 1'b0;
      req_ch.opcode       <= OP_ALLOC;
      req_ch.request_size <= '0;
      req_ch.block_index  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // class boundaries, fresh blocks in every class
      offer_word(OP_ALLOC, 8'd0,   5'd0);
      offer_word(OP_ALLOC, 8'd8,   5'd0);
      offer_word(OP_ALLOC, 8'd9,   5'd0);
      offer_word(OP_ALLOC, 8'd16,  5'd0);
      offer_word(OP_ALLOC, 8'd17,  5'd0);
      offer_word(OP_ALLOC, 8'd32,  5'd0);
      offer_word(OP_ALLOC, 8'd33,  5'd0);
      offer_word(OP_ALLOC, 8'd64,  5'd0);
      // oversized requests for both operations
      offer_word(OP_ALLOC, 8'd65,  5'd0);
      offer_word(OP_ALLOC, 8'd255, 5'd0);
      offer_word(OP_FREE,  8'd255, 5'd31);
      offer_word(OP_FREE,  8'd65,  5'd0);
      // free a never-allocated block, then LIFO pops and fall back to bump
      offer_word(OP_FREE,  8'd64,  5'd31);
      offer_word(OP_FREE,  8'd40,  5'd1);
      offer_word(OP_ALLOC, 8'd50,  5'd0);
      offer_word(OP_ALLOC, 8'd64,  5'd0);
      offer_word(OP_ALLOC, 8'd64,  5'd0);
      offer_word(OP_FREE,  8'd20,  5'd0);
      offer_word(OP_ALLOC, 8'd31,  5'd0);
      // freeing the same block twice
      offer_word(OP_FREE,  8'd0,   5'd21);
      offer_word(OP_FREE,  8'd1,   5'd21);
      offer_word(OP_ALLOC, 8'd2,   5'd0);
      offer_word(OP_ALLOC, 8'd3,   5'd0);

      // random phases with varying allocate pressure and class focus
      for (int p = 0; p < PHASES; p++) begin
         case ($urandom_range(0, 3))
            0:       alloc_pct = 25;
            1:       alloc_pct = 50;
            2:       alloc_pct = 75;
            default: alloc_pct = 95;
         endcase
         focus = $urandom_range(0, NUM_CLASSES);
         for (int n = 0; n < PHASE_ITEMS; n++) random_request(alloc_pct, focus);
      end
      if (offering) req_ch.valid <= 1'b0;

      // drain outstanding words, then let the pipeline settle
      @(posedge clock);
      while (waiting_grants != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Covered %0d requests (%0d allocates, %0d frees) in %0d cycles",
               alloc_sent + free_sent, alloc_sent, free_sent, cycle_count);
      $display("Responses: %0d ok, %0d pool exhausted, %0d size too large",
               ok_seen, exhausted_seen, too_large_seen);
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
